// File: hdl/gri_pkg.sv
// ----------------------------------------------------------------------------
// gri_pkg
// Shared types and constants for the gyro rate angle integrator.
// ----------------------------------------------------------------------------
package gri_pkg;

   localparam int FIELD_AXES   = 3;  // axes carried on the channels
   localparam int AXES         = 3;  // axes that are integrated
   localparam int HISTORY_TAPS = 3;

   localparam int RATE_W   = 13;
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = RATE_W + GAIN_W + 1;
   localparam int MAG_W    = 28;
   localparam int QUOT_W   = 14;
   localparam int SRATE_W  = QUOT_W + 1;
   localparam int ANGLE_W  = 26;
   localparam int SUM_W    = 17;
   localparam int SUM_MAG_W = SUM_W - 1;
   localparam int CSR_IDX_W = 2;

   // truncating divide by 24818 as exact reciprocal multiply for |p| < 2**28
   localparam longint unsigned RATE_DIVISOR = 64'd24818;
   localparam int RATE_SHIFT = 43;
   localparam int RATE_RECIP_W = 29;
   localparam logic [RATE_RECIP_W-1:0] RATE_RECIP =
      RATE_RECIP_W'(((64'd1 << RATE_SHIFT) + RATE_DIVISOR - 64'd1) / RATE_DIVISOR);

   // truncating divide by 6 for |sum| < 2**16
   localparam longint unsigned WEIGHT_DIVISOR = 64'd6;
   localparam int WEIGHT_SHIFT = 19;
   localparam int WEIGHT_RECIP_W = 17;
   localparam logic [WEIGHT_RECIP_W-1:0] WEIGHT_RECIP =
      WEIGHT_RECIP_W'(((64'd1 << WEIGHT_SHIFT) + WEIGHT_DIVISOR - 64'd1) / WEIGHT_DIVISOR);

   localparam logic signed [ANGLE_W+1:0] FULL_TURN = 28'sd36000000;

   localparam logic [ANGLE_W-1:0] START_ANGLE [FIELD_AXES] = '{
      26'd9000000, 26'd9000000, 26'd0
   };

   localparam logic CMD_INTEGRATE = 1'b0;
   localparam logic CMD_START     = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Z = 2'd2;

   typedef struct packed {
      logic load_s2;
      logic load_s3;
   } stage_ctl_type;

   typedef struct packed {
      logic load;
      logic command;
   } acc_ctl_type;

endpackage

// File: hdl/gri_req_if.sv
// ----------------------------------------------------------------------------
// gri_req_if
// Sample channel: command and one gyro sample per axis.
// ----------------------------------------------------------------------------
interface gri_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [gri_pkg::RATE_W-1:0]   rate_x;
   logic signed [gri_pkg::RATE_W-1:0]   rate_y;
   logic signed [gri_pkg::RATE_W-1:0]   rate_z;

   modport source (output valid, output command, output rate_x, output rate_y,
                   output rate_z, input ready);
   modport sink   (input valid, input command, input rate_x, input rate_y,
                   input rate_z, output ready);
endinterface

// File: hdl/gri_rsp_if.sv
// ----------------------------------------------------------------------------
// gri_rsp_if
// Result channel: the three axis angles after each transfer.
// ----------------------------------------------------------------------------
interface gri_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gri_pkg::ANGLE_W-1:0]   angle_x;
   logic [gri_pkg::ANGLE_W-1:0]   angle_y;
   logic [gri_pkg::ANGLE_W-1:0]   angle_z;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   input ready);
   modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                   output ready);
endinterface

// File: hdl/gri_rate_scale.sv
// ----------------------------------------------------------------------------
// gri_rate_scale
// Two pipeline stages: gain multiply, then truncating divide by 24818.
// ----------------------------------------------------------------------------
module gri_rate_scale (
   input  logic                                 clock,
   input  gri_pkg::stage_ctl_type               ctl,
   input  logic signed [gri_pkg::RATE_W-1:0]    rate,
   input  logic [gri_pkg::GAIN_W-1:0]           gain,
   output logic signed [gri_pkg::SRATE_W-1:0]   scaled_rate
);

   logic signed [gri_pkg::PROD_W-1:0]                        product_c;
   logic [gri_pkg::MAG_W-1:0]                                mag_c;
   logic [gri_pkg::MAG_W-1:0]                                mag_ff;
   logic                                                     neg_ff;
   logic [gri_pkg::MAG_W+gri_pkg::RATE_RECIP_W-1:0]          recip_prod_c;
   logic [gri_pkg::QUOT_W-1:0]                               quot_c;
   logic signed [gri_pkg::SRATE_W-1:0]                       rate_c;
   logic signed [gri_pkg::SRATE_W-1:0]                       rate_ff;

   assign product_c = rate * $signed({1'b0, gain});
   assign mag_c     = product_c[gri_pkg::PROD_W-1] ? gri_pkg::MAG_W'(-product_c)
                                                    : gri_pkg::MAG_W'(product_c);

   assign recip_prod_c = (gri_pkg::MAG_W+gri_pkg::RATE_RECIP_W)'(mag_ff)
                       * (gri_pkg::MAG_W+gri_pkg::RATE_RECIP_W)'(gri_pkg::RATE_RECIP);
   assign quot_c = recip_prod_c[gri_pkg::RATE_SHIFT+gri_pkg::QUOT_W-1:gri_pkg::RATE_SHIFT];
   assign rate_c = neg_ff ? -$signed({1'b0, quot_c}) : $signed({1'b0, quot_c});

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         mag_ff <= mag_c;
         neg_ff <= product_c[gri_pkg::PROD_W-1];
      end
      if (ctl.load_s3) begin
         rate_ff <= rate_c;
      end
   end

   assign scaled_rate = rate_ff;

endmodule

// File: hdl/gri_angle_acc.sv
// ----------------------------------------------------------------------------
// gri_angle_acc
// Per-axis rate history and angle register with weighted four-tap update.
// ----------------------------------------------------------------------------
module gri_angle_acc (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gri_pkg::acc_ctl_type                 ctl,
   input  logic signed [gri_pkg::SRATE_W-1:0]   scaled_rate,
   input  logic [gri_pkg::ANGLE_W-1:0]          start_angle,
   output logic [gri_pkg::ANGLE_W-1:0]          angle
);

   logic signed [gri_pkg::SRATE_W-1:0]                      hist_ff [gri_pkg::HISTORY_TAPS];
   logic [gri_pkg::ANGLE_W-1:0]                             angle_ff;
   logic [gri_pkg::ANGLE_W-1:0]                             angle_in;
   logic signed [gri_pkg::SUM_W-1:0]                        sum_c;
   logic signed [gri_pkg::SUM_W-1:0]                        tap_c;
   logic [gri_pkg::SUM_MAG_W-1:0]                           sum_mag_c;
   logic [gri_pkg::SUM_MAG_W+gri_pkg::WEIGHT_RECIP_W-1:0]   recip_prod_c;
   logic [gri_pkg::QUOT_W-1:0]                              quot_c;
   logic signed [gri_pkg::SRATE_W-1:0]                      delta_c;
   logic signed [gri_pkg::ANGLE_W+1:0]                      diff_c;

   always_comb begin
      sum_c = gri_pkg::SUM_W'(scaled_rate);
      tap_c = '0;
      for (int t = 0; t < gri_pkg::HISTORY_TAPS; t++) begin
         tap_c = gri_pkg::SUM_W'(hist_ff[t]);
         sum_c = sum_c + ((t == gri_pkg::HISTORY_TAPS - 1) ? tap_c : (tap_c <<< 1));
      end
   end

   assign sum_mag_c = sum_c[gri_pkg::SUM_W-1] ? gri_pkg::SUM_MAG_W'(-sum_c)
                                              : gri_pkg::SUM_MAG_W'(sum_c);
   assign recip_prod_c = (gri_pkg::SUM_MAG_W+gri_pkg::WEIGHT_RECIP_W)'(sum_mag_c)
                       * (gri_pkg::SUM_MAG_W+gri_pkg::WEIGHT_RECIP_W)'(gri_pkg::WEIGHT_RECIP);
   assign quot_c  = recip_prod_c[gri_pkg::WEIGHT_SHIFT+gri_pkg::QUOT_W-1:gri_pkg::WEIGHT_SHIFT];
   assign delta_c = sum_c[gri_pkg::SUM_W-1] ? -$signed({1'b0, quot_c})
                                            : $signed({1'b0, quot_c});

   always_comb begin
      diff_c = $signed({2'b00, angle_ff}) - (gri_pkg::ANGLE_W+2)'(delta_c);
      if (diff_c < 0) begin
         diff_c = diff_c + gri_pkg::FULL_TURN;
      end else if (diff_c >= gri_pkg::FULL_TURN) begin
         diff_c = diff_c - gri_pkg::FULL_TURN;
      end
      angle_in = diff_c[gri_pkg::ANGLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= start_angle;
         for (int t = 0; t < gri_pkg::HISTORY_TAPS; t++) begin
            hist_ff[t] <= '0;
         end
      end else if (ctl.load) begin
         if (ctl.command == gri_pkg::CMD_START) begin
            angle_ff <= start_angle;
         end else begin
            angle_ff   <= angle_in;
            hist_ff[0] <= scaled_rate;
            for (int t = 1; t < gri_pkg::HISTORY_TAPS; t++) begin
               hist_ff[t] <= hist_ff[t-1];
            end
         end
      end
   end

   assign angle = angle_ff;

endmodule

// File: hdl/gyro_rate_angle_integrator.sv
// ----------------------------------------------------------------------------
// gyro_rate_angle_integrator
// Three-axis gyro rate to angle integrator with per-axis gain registers.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out. Every sample passes four register stages
// (input, gain multiply, divide by 24818, angle update), and while the result
// side does not stall, a new sample is accepted every cycle; throughput is one
// sample per clock, set by the angle update loop in each axis accumulator. The
// result register holds the axis angles themselves, so a stalled result keeps
// the upstream stages filling until all of them are occupied. The user must
// write gains through the csr port only while no sample is in flight; the
// block itself does not enforce this.
module gyro_rate_angle_integrator (
   input  logic                              clock,
   input  logic                              reset,
   gri_req_if.sink                           req,
   gri_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic [gri_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gri_pkg::GAIN_W-1:0]        csr_write_data
);

   logic [gri_pkg::GAIN_W-1:0]            gain_ff [gri_pkg::FIELD_AXES];
   logic                                  s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                                  s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic signed [gri_pkg::RATE_W-1:0]     s1_rate_ff [gri_pkg::FIELD_AXES];
   logic signed [gri_pkg::SRATE_W-1:0]    scaled_rate [gri_pkg::FIELD_AXES];
   logic [gri_pkg::ANGLE_W-1:0]           angle [gri_pkg::FIELD_AXES];
   logic                                  ready_out, ready3, ready2, ready1;
   logic                                  load_s1;
   gri_pkg::stage_ctl_type                stage_ctl;
   gri_pkg::acc_ctl_type                  acc_ctl;

   assign ready_out = !out_valid_ff || rsp.ready;
   assign ready3    = !s3_valid_ff || ready_out;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req.ready = ready1;

   assign load_s1           = req.valid && ready1;
   assign stage_ctl.load_s2 = s1_valid_ff && ready2;
   assign stage_ctl.load_s3 = s2_valid_ff && ready3;
   assign acc_ctl.load      = s3_valid_ff && ready_out;
   assign acc_ctl.command   = s3_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= load_s1 || (s1_valid_ff && !ready2);
         s2_valid_ff  <= stage_ctl.load_s2 || (s2_valid_ff && !ready3);
         s3_valid_ff  <= stage_ctl.load_s3 || (s3_valid_ff && !ready_out);
         out_valid_ff <= acc_ctl.load || (out_valid_ff && !rsp.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_cmd_ff     <= req.command;
         s1_rate_ff[0] <= req.rate_x;
         s1_rate_ff[1] <= req.rate_y;
         s1_rate_ff[2] <= req.rate_z;
      end
      if (stage_ctl.load_s2) begin
         s2_cmd_ff <= s1_cmd_ff;
      end
      if (stage_ctl.load_s3) begin
         s3_cmd_ff <= s2_cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < gri_pkg::FIELD_AXES; a++) begin
            gain_ff[a] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            gri_pkg::CSR_GAIN_X: gain_ff[0] <= csr_write_data;
            gri_pkg::CSR_GAIN_Y: gain_ff[1] <= csr_write_data;
            gri_pkg::CSR_GAIN_Z: gain_ff[2] <= csr_write_data;
            default: ;
         endcase
      end
   end

   for (genvar a = 0; a < gri_pkg::FIELD_AXES; a++) begin : g_axis
      if (a < gri_pkg::AXES) begin : g_active
         gri_rate_scale u_scale (
            .clock       (clock),
            .ctl         (stage_ctl),
            .rate        (s1_rate_ff[a]),
            .gain        (gain_ff[a]),
            .scaled_rate (scaled_rate[a])
         );
         gri_angle_acc u_acc (
            .clock       (clock),
            .reset       (reset),
            .ctl         (acc_ctl),
            .scaled_rate (scaled_rate[a]),
            .start_angle (gri_pkg::START_ANGLE[a]),
            .angle       (angle[a])
         );
      end else begin : g_idle
         assign scaled_rate[a] = '0;
         assign angle[a]       = gri_pkg::START_ANGLE[a];
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.angle_x = angle[0];
   assign rsp.angle_y = angle[1];
   assign rsp.angle_z = angle[2];

   a_start_sets_angles: assert property (@(posedge clock) disable iff (reset)
      (acc_ctl.load && s3_cmd_ff == gri_pkg::CMD_START) |=>
         (angle[0] == gri_pkg::START_ANGLE[0]) && (angle[1] == gri_pkg::START_ANGLE[1])
         && (angle[2] == gri_pkg::START_ANGLE[2]))
      else $error("start command did not set the start angles");

   a_angles_in_range: assert property (@(posedge clock) disable iff (reset)
      ($signed({2'b00, angle[0]}) < gri_pkg::FULL_TURN)
      && ($signed({2'b00, angle[1]}) < gri_pkg::FULL_TURN)
      && ($signed({2'b00, angle[2]}) < gri_pkg::FULL_TURN))
      else $error("angle outside one full turn");

   a_angles_hold_without_load: assert property (@(posedge clock) disable iff (reset)
      !acc_ctl.load |=> $stable(angle[0]) && $stable(angle[1]) && $stable(angle[2]))
      else $error("angle changed without an update");

   a_update_fills_output: assert property (@(posedge clock) disable iff (reset)
      acc_ctl.load |=> out_valid_ff)
      else $error("angle update produced no result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff) |-> req.ready)
      else $error("empty pipeline refused a sample");

endmodule

// File: bench/gri_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gri_angle_checker
// Watches the sample, result and csr ports of the gyro rate angle integrator,
// keeps its own copy of the gains, rate history and axis angles, and checks
// each result transfer field by field against the oldest predicted angle set.
// ----------------------------------------------------------------------------
module gri_angle_checker (
   input  logic                           clock,
   input  logic                           reset,
   gri_req_if                             req_mon,
   gri_rsp_if                             rsp_mon,
   input  logic                           csr_write_enable,
   input  logic [gri_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gri_pkg::GAIN_W-1:0]     csr_write_data,
   output int                             mismatches,
   output int                             angles_pending,
   output int                             angles_checked
);

   localparam longint SCALE_DIVISOR = 24818;
   localparam longint TAP_DIVISOR   = 6;
   localparam longint TURN          = 36000000;

   typedef struct packed {
      logic [gri_pkg::ANGLE_W-1:0] x;
      logic [gri_pkg::ANGLE_W-1:0] y;
      logic [gri_pkg::ANGLE_W-1:0] z;
   } angle_set_type;

   logic [gri_pkg::ANGLE_W-1:0]        axis_angle [gri_pkg::FIELD_AXES];
   logic signed [gri_pkg::SRATE_W-1:0] rate_hist  [gri_pkg::FIELD_AXES][gri_pkg::HISTORY_TAPS];
   logic [gri_pkg::GAIN_W-1:0]         axis_gain  [gri_pkg::FIELD_AXES];
   angle_set_type                      expected_angles [$];
   int                                 mismatch_total;
   int                                 checked_total;

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
      mismatch_total++;
   endtask

   task automatic clear_state();
      for (int a = 0; a < gri_pkg::FIELD_AXES; a++) begin
         axis_angle[a] = gri_pkg::START_ANGLE[a];
         axis_gain[a]  = '0;
         for (int t = 0; t < gri_pkg::HISTORY_TAPS; t++)
            rate_hist[a][t] = '0;
      end
   endtask

   task automatic integrate_sample(input logic cmd,
                                   input logic signed [gri_pkg::RATE_W-1:0] rx,
                                   input logic signed [gri_pkg::RATE_W-1:0] ry,
                                   input logic signed [gri_pkg::RATE_W-1:0] rz);
      logic signed [gri_pkg::RATE_W-1:0] rate [gri_pkg::FIELD_AXES];
      longint                            scaled;
      longint                            weighted;
      longint                            next_angle;
      angle_set_type                     result;
      rate[0] = rx;
      rate[1] = ry;
      rate[2] = rz;
      if (cmd == gri_pkg::CMD_START) begin
         for (int a = 0; a < gri_pkg::AXES; a++)
            axis_angle[a] = gri_pkg::START_ANGLE[a];
      end else begin
         for (int a = 0; a < gri_pkg::AXES; a++) begin
            scaled = (longint'(rate[a]) * longint'(axis_gain[a])) / SCALE_DIVISOR;
            weighted = scaled + 2 * longint'(rate_hist[a][0])
                     + 2 * longint'(rate_hist[a][1]) + longint'(rate_hist[a][2]);
            next_angle = longint'(axis_angle[a]) - weighted / TAP_DIVISOR;
            if (next_angle >= TURN)
               next_angle -= TURN;
            if (next_angle < 0)
               next_angle += TURN;
            axis_angle[a] = gri_pkg::ANGLE_W'(next_angle);
            for (int t = gri_pkg::HISTORY_TAPS - 1; t > 0; t--)
               rate_hist[a][t] = rate_hist[a][t-1];
            rate_hist[a][0] = gri_pkg::SRATE_W'(scaled);
         end
      end
      result.x = axis_angle[0];
      result.y = axis_angle[1];
      result.z = axis_angle[2];
      expected_angles.push_back(result);
   endtask

   task automatic check_angles();
      angle_set_type want;
      if (expected_angles.size() == 0) begin
         report_mismatch("result transfer with no sample outstanding, angle_x",
                         rsp_mon.angle_x, 0);
      end else begin
         want = expected_angles.pop_front();
         checked_total++;
         if (rsp_mon.angle_x !== want.x)
            report_mismatch("angle_x", rsp_mon.angle_x, want.x);
         if (rsp_mon.angle_y !== want.y)
            report_mismatch("angle_y", rsp_mon.angle_y, want.y);
         if (rsp_mon.angle_z !== want.z)
            report_mismatch("angle_z", rsp_mon.angle_z, want.z);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_angles.delete();
         mismatch_total = 0;
         checked_total  = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               gri_pkg::CSR_GAIN_X: axis_gain[0] = csr_write_data;
               gri_pkg::CSR_GAIN_Y: axis_gain[1] = csr_write_data;
               gri_pkg::CSR_GAIN_Z: axis_gain[2] = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            integrate_sample(req_mon.command, req_mon.rate_x, req_mon.rate_y,
                             req_mon.rate_z);
         if (rsp_mon.valid && rsp_mon.ready)
            check_angles();
      end
      mismatches     <= mismatch_total;
      angles_pending <= expected_angles.size();
      angles_checked <= checked_total;
   end

endmodule

// File: bench/tb_gyro_rate_angle_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_rate_angle_integrator
// Drives gain writes and gyro samples into the integrator: a directed set of
// extremes, wraps and start commands, then random samples over several gain
// settings with mixes of sender gaps and result stalls. Checking is done by
// gri_angle_checker.
// ----------------------------------------------------------------------------
module tb_gyro_rate_angle_integrator;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 180;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int RESET_CYCLES = 11;

   localparam logic [gri_pkg::CSR_IDX_W-1:0]    CSR_UNUSED = 2'd3;
   localparam logic [gri_pkg::GAIN_W-1:0]       GAIN_MAX   = '1;
   localparam logic [gri_pkg::GAIN_W-1:0]       GAIN_UNITY = 16'd24818;
   localparam logic signed [gri_pkg::RATE_W-1:0] RATE_MIN  =
      {1'b1, {(gri_pkg::RATE_W-1){1'b0}}};
   localparam logic signed [gri_pkg::RATE_W-1:0] RATE_MAX  =
      {1'b0, {(gri_pkg::RATE_W-1){1'b1}}};
   localparam logic signed [gri_pkg::RATE_W-1:0] RATE_ALT0 = 13'h0AAA;
   localparam logic signed [gri_pkg::RATE_W-1:0] RATE_ALT1 = 13'h1555;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_write_enable;
   logic [gri_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gri_pkg::GAIN_W-1:0]     csr_write_data;
   int                             mismatches;
   int                             angles_pending;
   int                             angles_checked;
   int                             stall_pct;
   int                             send_idle_pct;
   int                             hold_left = 0;
   logic                           hold_req = 1'b0;
   logic                           hold_ack = 1'b0;
   int                             samples_sent;
   int                             start_cmds;

   gri_req_if req_ch ();
   gri_rsp_if rsp_ch ();

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   gyro_rate_angle_integrator dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gri_angle_checker angle_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .angles_pending   (angles_pending),
      .angles_checked   (angles_checked)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         rsp_ch.ready <= 1'b0;
         hold_ack     <= hold_req;
         hold_left    <= HOLD_CYCLES;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_csr(input logic [gri_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gri_pkg::GAIN_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [gri_pkg::GAIN_W-1:0] gx,
                            input logic [gri_pkg::GAIN_W-1:0] gy,
                            input logic [gri_pkg::GAIN_W-1:0] gz);
      write_csr(gri_pkg::CSR_GAIN_X, gx);
      write_csr(gri_pkg::CSR_GAIN_Y, gy);
      write_csr(gri_pkg::CSR_GAIN_Z, gz);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_sample(input logic cmd,
                              input logic signed [gri_pkg::RATE_W-1:0] rx,
                              input logic signed [gri_pkg::RATE_W-1:0] ry,
                              input logic signed [gri_pkg::RATE_W-1:0] rz);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.rate_x  <= rx;
      req_ch.rate_y  <= ry;
      req_ch.rate_z  <= rz;
      do @(posedge clock); while (!req_ch.ready);
      samples_sent++;
      if (cmd == gri_pkg::CMD_START)
         start_cmds++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (angles_pending != 0);
   endtask

   function automatic logic signed [gri_pkg::RATE_W-1:0] pick_rate();
      logic signed [gri_pkg::RATE_W-1:0] r;
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 4))
            0: r = RATE_MIN;
            1: r = RATE_MAX;
            2: r = '0;
            3: r = '1;
            default: r = 13'sd1;
         endcase
      end else begin
         r = gri_pkg::RATE_W'($urandom);
      end
      return r;
   endfunction

   task automatic send_random();
      logic cmd;
      cmd = ($urandom_range(0, 19) == 0) ? gri_pkg::CMD_START : gri_pkg::CMD_INTEGRATE;
      send_sample(cmd, pick_rate(), pick_rate(), pick_rate());
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.command   = gri_pkg::CMD_INTEGRATE;
      req_ch.rate_x    = '0;
      req_ch.rate_y    = '0;
      req_ch.rate_z    = '0;
      csr_write_enable = 1'b0;
      csr_index        = gri_pkg::CSR_GAIN_X;
      csr_write_data   = '0;
      stall_pct        = 0;
      send_idle_pct    = 0;
      samples_sent     = 0;
      start_cmds       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full gain, extremes, z wraps both ways, start mid-history
      set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
      send_sample(gri_pkg::CMD_START, RATE_MAX, RATE_MIN, RATE_ALT0);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MIN);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MIN);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MIN);
      send_sample(gri_pkg::CMD_INTEGRATE, '0, '0, '0);
      send_sample(gri_pkg::CMD_INTEGRATE, '1, 13'sd1, '1);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_ALT0, RATE_ALT1, RATE_ALT0);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_ALT1, RATE_ALT0, RATE_ALT1);
      send_sample(gri_pkg::CMD_START, '0, '0, '0);
      send_sample(gri_pkg::CMD_INTEGRATE, 13'sd1, '1, 13'sd1);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MAX, RATE_MIN, '0);

      // zero gain: only the history drains out; unused register index
      wait_drained();
      write_csr(CSR_UNUSED, GAIN_MAX);
      set_gains('0, '0, '0);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MAX, RATE_MIN, RATE_MAX);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MAX, RATE_MIN, RATE_MAX);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MIN, RATE_MAX, RATE_MIN);

      // unity and minimum gains: exact rates and truncation toward zero
      wait_drained();
      set_gains(16'd1, GAIN_UNITY, 16'd1);
      send_sample(gri_pkg::CMD_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MAX);
      send_sample(gri_pkg::CMD_INTEGRATE, '1, '1, 13'sd1);
      send_sample(gri_pkg::CMD_INTEGRATE, 13'sd7, -13'sd7, -13'sd5);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            1: set_gains('0, '0, '0);
            2: set_gains(16'd1, GAIN_MAX, GAIN_UNITY);
            default: set_gains(gri_pkg::GAIN_W'($urandom), gri_pkg::GAIN_W'($urandom),
                               gri_pkg::GAIN_W'($urandom));
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 53; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 53; end
            default: begin send_idle_pct = 32; stall_pct <= 32; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == 20)
               hold_req <= ~hold_req;
            if (p == 5 && i == PHASE_ITEMS / 2)
               wait_drained();
            send_random();
         end
      end

      wait_drained();
      stall_pct <= 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d samples (%0d start commands) over %0d gain settings,",
               samples_sent, start_cmds, PHASES + 3);
      $display("with sender gaps, result stalls, a long hold-off; %0d results checked",
               angles_checked);
      if (mismatches == 0 && angles_pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: gyro_rate_angle_integrator.f
hdl/gri_pkg.sv
hdl/gri_req_if.sv
hdl/gri_rsp_if.sv
hdl/gri_rate_scale.sv
hdl/gri_angle_acc.sv
hdl/gyro_rate_angle_integrator.sv
bench/gri_angle_checker.sv
bench/tb_gyro_rate_angle_integrator.sv
